// ===== rtl/core/frame_average_bad_reject_assert.svh =====
// Assertion helpers used by the frame averager RTL (frame_average_bad_reject.sv).
`ifndef FRAME_AVERAGE_BAD_REJECT_ASSERT_SVH
`define FRAME_AVERAGE_BAD_REJECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FAB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fab_pkg.sv =====
package fab_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int SUM_W = 48;
    localparam int CNT_W = 16;
    localparam int AVG_W = 32;
    localparam int CFG_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int EPF_W = 11;
    localparam int WIN_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_ADDR_W-1:0] REG_ELEMENTS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WHOLE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BAD      = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } fab_state_t;

endpackage

// ===== rtl/core/fab_ram.sv =====
module fab_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fab_div.sv =====
module fab_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [fab_pkg::SUM_W-1:0]    dividend,
    input  logic [fab_pkg::CNT_W-1:0]    divisor,
    output logic                         done,
    output logic [fab_pkg::SUM_W-1:0]    quotient
);

    localparam int STEP_W = $clog2(fab_pkg::SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(fab_pkg::SUM_W - 1);

    logic                        busy_reg, busy_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [fab_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [fab_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [fab_pkg::CNT_W-1:0]   dvs_reg, dvs_next;
    logic [fab_pkg::CNT_W:0]     trial;
    logic                        fits;

    // One quotient bit per cycle, restoring division.
    always_comb begin
        trial = {rem_reg, quo_reg[fab_pkg::SUM_W-1]};
        fits = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? fab_pkg::CNT_W'(trial - {1'b0, dvs_reg})
                            : trial[fab_pkg::CNT_W-1:0];
            quo_next = {quo_reg[fab_pkg::SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        step_reg <= step_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = busy_reg && (step_reg == LAST_STEP);
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/frame_average_bad_reject.sv =====
// Channel  Direction  tdata (low bit up)                     tuser              tlast
// s_       in         sample                                 final_frame        -
// m_       out        element_index, average, zero fill      no_valid_samples   last_of_frame
//
// A skipped beat is taken in ST_IDLE alone; an accumulated beat also passes ST_CALC (RAM read, then write).
// A beat that emits then runs the bit-serial 48 by 16 divider in ST_DIV, or goes to
// ST_DONE when the element has no valid sample; a stalled output register adds its wait.
// Reset is synchronous and clears control state only; the sum RAM is not cleared.
// A waiting result sits in the output register while the next beat is taken.
module frame_average_bad_reject #(
    parameter int MAX_ELEMENTS = fab_pkg::MAX_ELEMENTS_DEF,
    parameter int SAMPLE_WIDTH = fab_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [fab_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [fab_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
    // final_frame
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // element_index, average
    output logic [(((MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)
                    + fab_pkg::AVG_W + 7) / 8) * 8 - 1:0] m_tdata,
    // no_valid_samples
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    `include "frame_average_bad_reject_assert.svh"

    localparam int IDX_W = MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1;
    localparam int TD_W = ((IDX_W + fab_pkg::AVG_W + 7) / 8) * 8;
    localparam int SUM_W = fab_pkg::SUM_W;
    localparam int CNT_W = fab_pkg::CNT_W;
    localparam int RAM_W = SUM_W + CNT_W;
    localparam logic [16:0] MAX17 = 17'(MAX_ELEMENTS);
    localparam logic [SUM_W-1:0] POS_LIM = SUM_W'(64'h7FFF_FFFF);
    localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(64'h8000_0000);

    fab_pkg::fab_state_t state_reg, state_next;

    logic [fab_pkg::EPF_W-1:0] epf_reg;
    logic [fab_pkg::WIN_W-1:0] win_reg, start_reg;
    logic                      whole_reg;
    logic [31:0]               bad_reg;

    logic [IDX_W-1:0] elem_reg;
    logic [15:0]      fiw_reg, skipped_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [SUM_W-1:0] smp_reg;
    logic             valid_reg, first_reg, emit_reg, last_reg;
    logic             neg_reg, cnt_zero_reg;

    logic             m_valid_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic [31:0]      m_avg_reg;
    logic             m_zero_reg, m_last_reg;

    logic [16:0]      epf_eff, epf_m1;
    logic [15:0]      win_m1;
    logic             s_acc, last_elem, skip_now, win_end, emit_now;
    logic signed [SAMPLE_WIDTH-1:0] smp_in;
    logic [SUM_W-1:0] smp_ext, bad_ext;

    logic [RAM_W-1:0] ram_rdata;
    logic [SUM_W-1:0] sum_old, sum_new, sum_mag;
    logic [CNT_W-1:0] cnt_old, cnt_new;
    logic             ram_we, div_start, div_done, out_load;
    logic [SUM_W-1:0] div_q;
    logic [31:0]      avg_sat;

    always_comb begin
        epf_eff = (epf_reg == '0) ? 17'd1 : 17'(epf_reg);
        if (epf_eff > MAX17) begin
            epf_eff = MAX17;
        end
        epf_m1 = epf_eff - 17'd1;
        win_m1 = (win_reg == '0) ? 16'd0 : win_reg - 16'd1;
    end

    assign s_tready = (state_reg == fab_pkg::ST_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign last_elem = 17'(elem_reg) >= epf_m1;
    assign skip_now = skipped_reg < start_reg;
    assign win_end = fiw_reg >= win_m1;
    assign emit_now = whole_reg ? s_tuser : (s_tuser || win_end);
    assign smp_in = s_tdata[SAMPLE_WIDTH-1:0];
    assign smp_ext = SUM_W'(smp_in);
    assign bad_ext = SUM_W'(signed'(bad_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epf_reg <= fab_pkg::EPF_W'(1024);
            win_reg <= 16'd1;
            start_reg <= 16'd0;
            whole_reg <= 1'b0;
            bad_reg <= 32'h8000_0000;
        end else if (cfg_we) begin
            case (cfg_addr)
                fab_pkg::REG_ELEMENTS: epf_reg <= cfg_wdata[fab_pkg::EPF_W-1:0];
                fab_pkg::REG_WINDOW:   win_reg <= cfg_wdata[fab_pkg::WIN_W-1:0];
                fab_pkg::REG_START:    start_reg <= cfg_wdata[fab_pkg::WIN_W-1:0];
                fab_pkg::REG_WHOLE:    whole_reg <= cfg_wdata[0];
                fab_pkg::REG_BAD:      bad_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_reg <= '0;
            fiw_reg <= '0;
            skipped_reg <= '0;
        end else if (s_acc) begin
            elem_reg <= last_elem ? '0 : elem_reg + 1'b1;
            if (skip_now) begin
                if (last_elem) begin
                    skipped_reg <= s_tuser ? 16'd0 : skipped_reg + 16'd1;
                end
            end else if (last_elem) begin
                if (s_tuser) begin
                    fiw_reg <= '0;
                    skipped_reg <= '0;
                end else if (!whole_reg && win_end) begin
                    fiw_reg <= '0;
                end else if (fiw_reg != 16'hFFFF) begin
                    fiw_reg <= fiw_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            idx_reg <= elem_reg;
            smp_reg <= smp_ext;
            valid_reg <= smp_ext != bad_ext;
            first_reg <= fiw_reg == '0;
            emit_reg <= emit_now;
            last_reg <= last_elem;
        end
    end

    fab_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_ELEMENTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(idx_reg),
        .wdata({cnt_new, sum_new}),
        .re   (s_acc),
        .raddr(elem_reg),
        .rdata(ram_rdata)
    );

    assign sum_old = ram_rdata[SUM_W-1:0];
    assign cnt_old = ram_rdata[RAM_W-1:SUM_W];

    always_comb begin
        if (first_reg) begin
            sum_new = valid_reg ? smp_reg : '0;
            cnt_new = valid_reg ? CNT_W'(1) : '0;
        end else if (valid_reg && cnt_old != fab_pkg::CNT_MAX) begin
            sum_new = sum_old + smp_reg;
            cnt_new = cnt_old + 1'b1;
        end else begin
            sum_new = sum_old;
            cnt_new = cnt_old;
        end
        sum_mag = sum_new[SUM_W-1] ? -sum_new : sum_new;
    end

    assign ram_we = (state_reg == fab_pkg::ST_CALC);
    assign div_start = ram_we && emit_reg && (cnt_new != '0);

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            neg_reg <= sum_new[SUM_W-1];
            cnt_zero_reg <= cnt_new == '0;
        end
    end

    fab_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(sum_mag),
        .divisor (cnt_new),
        .done    (div_done),
        .quotient(div_q)
    );

    always_comb begin
        if (cnt_zero_reg) begin
            avg_sat = '0;
        end else if (neg_reg) begin
            avg_sat = (div_q > NEG_LIM) ? 32'h8000_0000 : 32'(-div_q);
        end else begin
            avg_sat = (div_q > POS_LIM) ? 32'h7FFF_FFFF : div_q[31:0];
        end
    end

    assign out_load = (state_reg == fab_pkg::ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fab_pkg::ST_IDLE: begin
                if (s_acc && !skip_now) begin
                    state_next = fab_pkg::ST_CALC;
                end
            end
            fab_pkg::ST_CALC: begin
                if (!emit_reg) begin
                    state_next = fab_pkg::ST_IDLE;
                end else if (cnt_new == '0) begin
                    state_next = fab_pkg::ST_DONE;
                end else begin
                    state_next = fab_pkg::ST_DIV;
                end
            end
            fab_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = fab_pkg::ST_DONE;
                end
            end
            fab_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = fab_pkg::ST_IDLE;
                end
            end
            default: state_next = fab_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fab_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_idx_reg <= idx_reg;
            m_avg_reg <= avg_sat;
            m_zero_reg <= cnt_zero_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = TD_W'({m_avg_reg, m_idx_reg});
    assign m_tuser = m_zero_reg;
    assign m_tlast = m_last_reg;

    `FAB_ASSERT_NEXT(a_accum_goes_calc, aclk, aresetn, s_acc && !skip_now, state_reg == fab_pkg::ST_CALC, "accumulated beat did not reach the update cycle")
    `FAB_ASSERT_NEXT(a_skip_stays_idle, aclk, aresetn, s_acc && skip_now, state_reg == fab_pkg::ST_IDLE, "skipped beat started a memory update")
    `FAB_ASSERT_NOW(a_div_done_in_div, aclk, aresetn, div_done, state_reg == fab_pkg::ST_DIV, "divider finished outside the divide state")
    `FAB_ASSERT_NOW(a_empty_avg_zero, aclk, aresetn, out_load && cnt_zero_reg, avg_sat == 32'd0, "element without valid samples has a nonzero average")

endmodule

// ===== verif/frame_average_checker.sv =====
module frame_average_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [9:0]  idx;
        logic [31:0] avg;
        logic        none;
        logic        last;
    } avg_beat_t;

    avg_beat_t expected_avgs[$];

    logic signed [47:0] elem_sum [1024];
    logic [15:0]        elem_cnt [1024];
    logic [10:0]        epf_reg;
    logic [15:0]        win_reg;
    logic [15:0]        start_reg;
    logic               whole_reg;
    logic [31:0]        bad_reg;
    logic [15:0]        elem_pos;
    logic [15:0]        frame_pos;
    logic [15:0]        skipped;

    assign pending_count = expected_avgs.size();

    task automatic accumulate(input logic [31:0] smp, input logic fin);
        int unsigned epf, win, e;
        logic lastel, valid, emit;
        logic signed [47:0] s, sm;
        logic signed [63:0] q;
        logic [15:0] c;
        avg_beat_t b;
        begin
            epf = 32'(epf_reg);
            win = (win_reg == 0) ? 1 : 32'(win_reg);
            if (epf == 0) epf = 1;
            if (epf > 1024) epf = 1024;
            lastel = elem_pos >= epf - 1;
            e = (elem_pos >= 1024) ? 1023 : 32'(elem_pos);
            if (skipped < start_reg) begin
                if (lastel) skipped = fin ? 16'd0 : skipped + 16'd1;
            end else begin
                s = {{16{smp[31]}}, smp};
                valid = smp != bad_reg;
                if (frame_pos == 0) begin
                    sm = valid ? s : 48'sd0;
                    c = valid ? 16'd1 : 16'd0;
                end else begin
                    sm = elem_sum[e];
                    c = elem_cnt[e];
                    if (valid && c != 16'hffff) begin
                        sm = sm + s;
                        c = c + 16'd1;
                    end
                end
                elem_sum[e] = sm;
                elem_cnt[e] = c;
                emit = whole_reg ? fin : (fin || frame_pos >= win - 1);
                if (emit) begin
                    q = 0;
                    if (c != 0) begin
                        q = 64'(sm) / $signed({48'd0, c});
                        if (q > 64'sh7fffffff) q = 64'sh7fffffff;
                        if (q < -64'sh80000000) q = -64'sh80000000;
                    end
                    b.idx = e[9:0];
                    b.avg = q[31:0];
                    b.none = c == 0;
                    b.last = lastel;
                    expected_avgs.push_back(b);
                end
                if (lastel) begin
                    if (fin) begin
                        frame_pos = 0;
                        skipped = 0;
                    end else if (!whole_reg && frame_pos >= win - 1) begin
                        frame_pos = 0;
                    end else if (frame_pos != 16'hffff) begin
                        frame_pos = frame_pos + 16'd1;
                    end
                end
            end
            elem_pos = lastel ? 16'd0 : elem_pos + 16'd1;
        end
    endtask

    always @(posedge aclk) begin
        avg_beat_t got, exp_b;
        if (!aresetn) begin
            epf_reg <= 11'd1024;
            win_reg <= 16'd1;
            start_reg <= 16'd0;
            whole_reg <= 1'b0;
            bad_reg <= 32'h80000000;
            elem_pos = 0;
            frame_pos = 0;
            skipped = 0;
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    fab_pkg::REG_ELEMENTS: epf_reg <= cfg_wdata[10:0];
                    fab_pkg::REG_WINDOW:   win_reg <= cfg_wdata[15:0];
                    fab_pkg::REG_START:    start_reg <= cfg_wdata[15:0];
                    fab_pkg::REG_WHOLE:    whole_reg <= cfg_wdata[0];
                    fab_pkg::REG_BAD:      bad_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) accumulate(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[9:0], m_tdata[41:10], m_tuser, m_tlast};
                if (expected_avgs.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_b = expected_avgs.pop_front();
                    if (got !== exp_b) begin
                        $display("%0t: mismatch, expected idx %0d avg %h none %b last %b, actual idx %0d avg %h none %b last %b",
                                 $time, exp_b.idx, exp_b.avg, exp_b.none, exp_b.last,
                                 got.idx, got.avg, got.none, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/tb_frame_average_bad_reject.sv =====
module tb_frame_average_bad_reject;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending_count;
    int          cycles;
    int          max_stall;
    logic [31:0] bad_now;

    frame_average_bad_reject u_top (.*);

    frame_average_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 3000000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int n;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (m_tready && m_tvalid) begin
                n = (max_stall == 0) ? 0 : $urandom_range(0, 15);
                if (n != 0) begin
                    m_tready <= 0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
        begin
            cfg_we <= 1;
            cfg_addr <= a;
            cfg_wdata <= d;
            @(posedge aclk);
        end
    endtask

    task automatic send_sample(input logic [31:0] d, input logic fin);
        int g;
        begin
            g = (max_stall == 0) ? 0 : $urandom_range(0, 15);
            if (g != 0) begin
                s_tvalid <= 0;
                repeat (g) @(posedge aclk);
            end
            s_tvalid <= 1;
            s_tdata <= d;
            s_tuser <= fin;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
    endtask

    task automatic drain;
        begin
            s_tvalid <= 0;
            while (pending_count != 0) @(posedge aclk);
            repeat (200) @(posedge aclk);
        end
    endtask

    task automatic configure(input int epf, input int win, input int st,
                             input logic whole, input logic [31:0] bad);
        begin
            drain();
            write_reg(fab_pkg::REG_ELEMENTS, epf);
            write_reg(fab_pkg::REG_WINDOW, win);
            write_reg(fab_pkg::REG_START, st);
            write_reg(fab_pkg::REG_WHOLE, {31'd0, whole});
            write_reg(fab_pkg::REG_BAD, bad);
            cfg_we <= 0;
            bad_now = bad;
        end
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return bad_now;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_series(input int epf, input int frames);
        int f, e;
        begin
            for (f = 0; f < frames; f++)
                for (e = 0; e < epf; e++)
                    send_sample(rand_sample(), f == frames - 1);
        end
    endtask

    initial begin
        int items, epf, fr;
        aresetn = 0;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        max_stall = 15;
        bad_now = 32'h80000000;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        configure(4, 2, 1, 1'b0, 32'h80000000);
        send_sample(32'h1, 0); send_sample(32'h2, 0);
        send_sample(32'h3, 0); send_sample(32'h4, 0);
        send_sample(32'h7fffffff, 0); send_sample(32'h80000000, 0);
        send_sample(32'hffffffff, 0); send_sample(32'h0, 0);
        send_sample(32'h7fffffff, 0); send_sample(32'h80000000, 0);
        send_sample(32'hfffffffd, 0); send_sample(32'h5, 0);
        send_sample(32'h9, 1); send_sample(32'h80000000, 1);
        send_sample(32'h3, 1); send_sample(32'h7, 1);
        configure(2, 0, 3, 1'b0, 32'h0);
        send_series(2, 2);
        configure(1, 65535, 0, 1'b1, 32'h7fffffff);
        send_sample(32'h7fffffff, 0); send_sample(32'h10, 0);
        send_sample(32'h7fffffff, 1);
        configure(0, 1, 0, 1'b0, 32'h12345678);
        send_sample(32'h12345678, 0); send_sample(32'h5, 1);

        items = 0;
        while (items < 1400) begin
            epf = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 6);
            max_stall = ($urandom_range(0, 4) == 0) ? 0 : 15;
            configure(epf, $urandom_range(0, 4), $urandom_range(0, 2), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) != 0) ? $urandom() : 32'h80000000);
            fr = (epf > 64) ? 1 : $urandom_range(1, 12);
            send_series(epf, fr);
            items += epf * fr;
        end
        configure(1024, 1, 0, 1'b0, 32'h80000000);
        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
